// File: design/alloc_event_frame_statistics_assert.svh
// Assertion macros used by the checker file.
`ifndef ALLOC_EVENT_FRAME_STATISTICS_ASSERT_SVH
`define ALLOC_EVENT_FRAME_STATISTICS_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define AEFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AEFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: design/aefs_pkg.sv
`timescale 1ns / 1ps
package aefs_pkg;
  localparam int HistBuckets = 16;
  localparam int AvgWindow = 120;
  localparam int ScalarWords = 13;
  localparam int WordCount = ScalarWords + 2 * HistBuckets;
  localparam int BucketW = $clog2(HistBuckets);
  localparam int WinW = $clog2(AvgWindow + 1);
  localparam int WinAw = $clog2(AvgWindow);

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_BEGIN = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  localparam logic [5:0] W_AVG_CALLS = 6'd8;
  localparam logic [5:0] W_AVG_BYTES = 6'd9;
  localparam logic [5:0] W_PEAK_CALLS = 6'd10;
  localparam logic [5:0] W_PEAK_BYTES = 6'd11;
  localparam logic [5:0] W_VIOL = 6'd12;

  // Smallest bucket whose limit 16 << b covers the size, capped at the top bucket.
  function automatic logic [BucketW-1:0] size_bucket(input logic [31:0] size);
    logic [BucketW-1:0] b;
    b = BucketW'(HistBuckets - 1);
    for (int i = HistBuckets - 2; i >= 0; i--) begin
      if ({32'd0, size} <= (64'd16 << i)) b = BucketW'(i);
    end
    return b;
  endfunction
endpackage

// File: design/aefs_ram.sv
`timescale 1ns / 1ps
module aefs_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/aefs_div.sv
`timescale 1ns / 1ps
module aefs_div
  import aefs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [63:0]     dividend,
  input  logic [WinW-1:0] divisor,
  output logic            done,
  output logic [63:0]     quotient
);
  logic [63:0]     q_r, q_nxt, q_step;
  logic [WinW-1:0] rem_r, rem_nxt, rem_step;
  logic [6:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [WinW:0]   trial;
  logic            fits;

  // Restoring division, one quotient bit a cycle. The remainder stays below the divisor,
  // so it never needs more than WinW bits.
  always_comb begin
    trial = {rem_r, q_r[63]};
    fits = trial >= {1'b0, divisor};
    rem_step = fits ? WinW'(trial - {1'b0, divisor}) : trial[WinW-1:0];
    q_step = {q_r[62:0], fits};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = q_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  // The final quotient bit is formed in the last busy cycle; a new start may share that cycle.
  assign done = busy_r && (cnt_r == 7'd1);
  assign quotient = q_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end
endmodule

// File: design/alloc_event_frame_statistics.sv
`timescale 1ns / 1ps
// Allocation monitor. Alloc and free events are taken one a cycle while the block is running
// and no report word is waiting; the histogram update is a read-modify-write of two 16-entry
// memories, with forwarding from the write stage and from the entry just written when either
// holds the same bucket. Frame begin clears the histogram by a sweep over its 16 buckets.
// A recorded frame end reads and writes the 120-entry moving-window memories, divides both
// window sums by a bit-serial divider and then streams 45 report words, one a cycle while the
// receiver does not stall, with a read state after each histogram bucket but the last. After
// reset a 120-entry pass clears window and histogram RAMs before any item is taken.
module alloc_event_frame_statistics
  import aefs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // histogram_enable
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,       // kind[1:0]
  input  logic [39:0] in_tdata,       // size[31:0], on_main_thread[32],
                                      // in_disallow_scope[33], record[34], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,      // word_index[5:0], word_value[69:6], zero fill
  output logic        out_tlast       // last_word
);
  typedef enum logic [3:0] {
    S_CLR_WIN, S_RUN, S_CLR_HIST, S_WRD, S_WUPD, S_DIVC, S_DIVB, S_HREAD, S_HOUT
  } state_t;

  state_t state_r;
  logic hen_r;
  logic [63:0] cnt_r [8];
  logic [63:0] viol_r, wcs_r, wbs_r, pkc_r, pkb_r, avgc_r, avgb_r;
  logic [WinAw-1:0] wpos_r;
  logic [WinW-1:0]  wfill_r;
  logic [5:0]  widx_r;
  logic [BucketW-1:0] hb_r;
  logic [6:0]  clr_r;

  // histogram pipeline stages
  logic              hp_v_r;
  logic [BucketW-1:0] hp_b_r;
  logic [31:0]       hp_sz_r;
  logic              hw_v_r;
  logic [BucketW-1:0] hw_b_r;
  logic [63:0]       hw_c_r, hw_y_r;
  // copy of the entry written at the last edge, which the memory read missed
  logic              hx_v_r;
  logic [BucketW-1:0] hx_b_r;
  logic [63:0]       hx_c_r, hx_y_r;

  logic [1:0]  kind;
  logic [31:0] size;
  logic mt, dis, rec, acc;
  assign kind = in_tuser;
  assign size = in_tdata[31:0];
  assign mt = in_tdata[32];
  assign dis = in_tdata[33];
  assign rec = in_tdata[34];
  assign in_tready = (state_r == S_RUN) && !out_tvalid;
  assign acc = in_tvalid && in_tready;

  // histogram memories
  logic hc_we;
  logic [BucketW-1:0] hc_wa, hc_ra;
  logic [63:0] hc_wd_c, hc_wd_b, hc_rd_c, hc_rd_b;
  // window memories
  logic w_we;
  logic [WinAw-1:0] w_wa;
  logic [63:0] w_wd_c, w_wd_b, w_rd_c, w_rd_b;

  aefs_ram #(.Width(64), .Depth(HistBuckets)) u_hcalls (
    .clk, .we(hc_we), .waddr(hc_wa), .wdata(hc_wd_c), .raddr(hc_ra), .rdata(hc_rd_c));
  aefs_ram #(.Width(64), .Depth(HistBuckets)) u_hbytes (
    .clk, .we(hc_we), .waddr(hc_wa), .wdata(hc_wd_b), .raddr(hc_ra), .rdata(hc_rd_b));
  aefs_ram #(.Width(64), .Depth(AvgWindow)) u_wcalls (
    .clk, .we(w_we), .waddr(w_wa), .wdata(w_wd_c), .raddr(wpos_r), .rdata(w_rd_c));
  aefs_ram #(.Width(64), .Depth(AvgWindow)) u_wbytes (
    .clk, .we(w_we), .waddr(w_wa), .wdata(w_wd_b), .raddr(wpos_r), .rdata(w_rd_b));

  logic div_start, div_done;
  logic [63:0] div_q, div_a;
  assign div_a = (state_r == S_WUPD) ? (wcs_r - w_rd_c + cnt_r[0]) : wbs_r;
  aefs_div u_div (.clk, .rst_n, .start(div_start), .dividend(div_a),
    .divisor(wfill_r), .done(div_done), .quotient(div_q));

  // Histogram read-modify-write with forwarding from the write stage and the entry just written.
  logic [63:0] old_c, old_b;
  always_comb begin
    if (hw_v_r && hw_b_r == hp_b_r) begin
      old_c = hw_c_r;
      old_b = hw_y_r;
    end else if (hx_v_r && hx_b_r == hp_b_r) begin
      old_c = hx_c_r;
      old_b = hx_y_r;
    end else begin
      old_c = hc_rd_c;
      old_b = hc_rd_b;
    end
  end

  always_comb begin
    hc_we = hw_v_r;
    hc_wa = hw_b_r;
    hc_wd_c = hw_c_r;
    hc_wd_b = hw_y_r;
    if (state_r == S_CLR_HIST || (state_r == S_CLR_WIN && clr_r < 7'(HistBuckets))) begin
      hc_we = 1'b1;
      hc_wa = clr_r[BucketW-1:0];
      hc_wd_c = '0;
      hc_wd_b = '0;
    end
    hc_ra = (state_r == S_HREAD || state_r == S_HOUT) ? hb_r : size_bucket(size);
    w_we = (state_r == S_CLR_WIN) || (state_r == S_WUPD);
    w_wa = (state_r == S_CLR_WIN) ? clr_r[WinAw-1:0] : wpos_r;
    w_wd_c = (state_r == S_CLR_WIN) ? 64'd0 : cnt_r[0];
    w_wd_b = (state_r == S_CLR_WIN) ? 64'd0 : cnt_r[1];
    div_start = (state_r == S_WUPD) || (state_r == S_DIVC && div_done);
  end

  // hold-word for the histogram stream: calls then bytes of each bucket
  logic hsel_r;
  logic [63:0] hbytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_WIN;
      clr_r <= '0;
      hen_r <= 1'b0;
      out_tvalid <= 1'b0;
      hp_v_r <= 1'b0;
      hw_v_r <= 1'b0;
      hx_v_r <= 1'b0;
      for (int i = 0; i < 8; i++) cnt_r[i] <= '0;
      viol_r <= '0; wcs_r <= '0; wbs_r <= '0; pkc_r <= '0; pkb_r <= '0;
      wpos_r <= '0; wfill_r <= '0;
    end else begin
      if (cfg_wr_en) hen_r <= cfg_wr_data;
      hx_v_r <= hw_v_r;
      hx_b_r <= hw_b_r;
      hx_c_r <= hw_c_r;
      hx_y_r <= hw_y_r;
      hw_v_r <= hp_v_r;
      if (hp_v_r) begin
        hw_b_r <= hp_b_r;
        hw_c_r <= old_c + 64'd1;
        hw_y_r <= old_b + {32'd0, hp_sz_r};
      end
      hp_v_r <= acc && kind == KIND_ALLOC && hen_r;
      hp_b_r <= size_bucket(size);
      hp_sz_r <= size;
      // While streaming the report the next word is loaded in the same cycle instead.
      if (out_tvalid && out_tready && state_r != S_HOUT) out_tvalid <= 1'b0;
      unique case (state_r)
        S_CLR_WIN: begin
          clr_r <= clr_r + 7'd1;
          if (clr_r == 7'(AvgWindow - 1)) state_r <= S_RUN;
        end
        S_RUN: if (acc) begin
          unique case (kind_t'(kind))
            KIND_ALLOC: begin
              cnt_r[4] <= cnt_r[4] + 64'd1;
              cnt_r[5] <= cnt_r[5] + {32'd0, size};
              if (mt) begin
                cnt_r[0] <= cnt_r[0] + 64'd1;
                cnt_r[1] <= cnt_r[1] + {32'd0, size};
              end
              if (dis) viol_r <= viol_r + 64'd1;
            end
            KIND_FREE: begin
              cnt_r[6] <= cnt_r[6] + 64'd1;
              cnt_r[7] <= cnt_r[7] + {32'd0, size};
              if (mt) begin
                cnt_r[2] <= cnt_r[2] + 64'd1;
                cnt_r[3] <= cnt_r[3] + {32'd0, size};
              end
            end
            KIND_BEGIN: begin
              for (int i = 0; i < 8; i++) cnt_r[i] <= '0;
              viol_r <= '0;
              clr_r <= '0;
              state_r <= S_CLR_HIST;
            end
            KIND_END: if (rec) begin
              if (wfill_r != WinW'(AvgWindow)) wfill_r <= wfill_r + WinW'(1);
              state_r <= S_WRD;
            end
          endcase
        end
        S_CLR_HIST: begin
          clr_r <= clr_r + 7'd1;
          if (clr_r == 7'(HistBuckets - 1)) state_r <= S_RUN;
        end
        S_WRD: state_r <= S_WUPD;
        S_WUPD: begin
          wcs_r <= wcs_r - w_rd_c + cnt_r[0];
          wbs_r <= wbs_r - w_rd_b + cnt_r[1];
          wpos_r <= (wpos_r == WinAw'(AvgWindow - 1)) ? '0 : wpos_r + WinAw'(1);
          if (cnt_r[0] > pkc_r) pkc_r <= cnt_r[0];
          if (cnt_r[1] > pkb_r) pkb_r <= cnt_r[1];
          state_r <= S_DIVC;
        end
        S_DIVC: if (div_done) begin
          avgc_r <= div_q;
          state_r <= S_DIVB;
        end
        S_DIVB: if (div_done) begin
          avgb_r <= div_q;
          widx_r <= '0;
          state_r <= S_HOUT;
          hb_r <= '0;
          hsel_r <= 1'b0;
        end
        S_HREAD: state_r <= S_HOUT;
        S_HOUT: if (!out_tvalid || out_tready) begin
          out_tvalid <= 1'b1;
          out_tlast <= widx_r == 6'(WordCount - 1);
          out_tdata[5:0] <= widx_r;
          out_tdata[71:70] <= '0;
          priority if (widx_r < 6'd8) out_tdata[69:6] <= cnt_r[widx_r[2:0]];
          else if (widx_r == W_AVG_CALLS) out_tdata[69:6] <= avgc_r;
          else if (widx_r == W_AVG_BYTES) out_tdata[69:6] <= avgb_r;
          else if (widx_r == W_PEAK_CALLS) out_tdata[69:6] <= pkc_r;
          else if (widx_r == W_PEAK_BYTES) out_tdata[69:6] <= pkb_r;
          else if (widx_r == W_VIOL) out_tdata[69:6] <= viol_r;
          else if (!hsel_r) begin
            out_tdata[69:6] <= hc_rd_c;
            hbytes_r <= hc_rd_b;
          end else out_tdata[69:6] <= hbytes_r;
          widx_r <= widx_r + 6'd1;
          if (widx_r > W_VIOL) hsel_r <= !hsel_r;
          if (widx_r > W_VIOL && hsel_r) hb_r <= hb_r + BucketW'(1);
          if (widx_r == 6'(WordCount - 1)) state_r <= S_RUN;
          else if (widx_r > W_VIOL && hsel_r) state_r <= S_HREAD;
        end
        default: state_r <= S_RUN;
      endcase
    end
  end
endmodule

// File: design/aefs_checker.sv
`timescale 1ns / 1ps
`include "alloc_event_frame_statistics_assert.svh"
module aefs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast
);
  `AEFS_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_tvalid, !in_tready)
  `AEFS_ASSERT_IMP(a_last_index, clk, rst_n, out_tvalid && out_tlast, out_tdata[5:0] == 6'd44)
  `AEFS_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[71:70] == 2'd0)
  `AEFS_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind alloc_event_frame_statistics aefs_checker u_aefs_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import aefs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;       // kind
  logic [39:0] in_tdata = '0;       // size, on_main_thread, in_disallow_scope, record
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;           // word_index, word_value
  logic        out_tlast;

  always #1 clk = ~clk;

  alloc_event_frame_statistics DUT (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  typedef struct packed {
    kind_t       kind;
    logic [31:0] size;
    logic        main_thr;
    logic        disallow;
    logic        rec;
  } event_t;

  typedef struct {
    logic [5:0]  idx;
    logic [63:0] value;
    logic        last;
  } report_word_t;

  // Own copy of the monitor state.
  logic        hist_on;
  logic [63:0] m_ac, m_ab, m_fc, m_fb, a_ac, a_ab, a_fc, a_fb, viol;
  logic [63:0] h_calls [HistBuckets];
  logic [63:0] h_bytes [HistBuckets];
  logic [63:0] w_calls [AvgWindow];
  logic [63:0] w_bytes [AvgWindow];
  int          w_pos, w_fill;
  logic [63:0] w_csum, w_bsum, pk_c, pk_b;

  report_word_t report_q[$];
  int errors = 0;

  function automatic int bucket_of(logic [31:0] sz);
    logic [63:0] lim;
    int b;
    b = 0;
    lim = 64'd16;
    while (b + 1 < HistBuckets && {32'd0, sz} > lim) begin
      lim = lim << 1;
      b++;
    end
    return b;
  endfunction

  task automatic clear_frame();
    {m_ac, m_ab, m_fc, m_fb, a_ac, a_ab, a_fc, a_fb, viol} = '0;
    for (int i = 0; i < HistBuckets; i++) begin
      h_calls[i] = '0;
      h_bytes[i] = '0;
    end
  endtask

  task automatic push_word(int idx, logic [63:0] v, logic l);
    report_word_t w;
    w.idx = 6'(idx);
    w.value = v;
    w.last = l;
    report_q.push_back(w);
  endtask

  task automatic predict_event(event_t e);
    int b;
    logic [63:0] s;
    logic [63:0] sc [ScalarWords];
    s = {32'd0, e.size};
    case (e.kind)
      KIND_ALLOC: begin
        a_ac++; a_ab += s;
        if (e.main_thr) begin
          m_ac++; m_ab += s;
        end
        if (hist_on) begin
          b = bucket_of(e.size);
          h_calls[b]++;
          h_bytes[b] += s;
        end
        if (e.disallow) viol++;
      end
      KIND_FREE: begin
        a_fc++; a_fb += s;
        if (e.main_thr) begin
          m_fc++; m_fb += s;
        end
      end
      KIND_BEGIN: clear_frame();
      default: begin
        if (e.rec) begin
          w_csum -= w_calls[w_pos];
          w_bsum -= w_bytes[w_pos];
          w_calls[w_pos] = m_ac;
          w_bytes[w_pos] = m_ab;
          w_csum += m_ac;
          w_bsum += m_ab;
          w_pos = (w_pos + 1) % AvgWindow;
          if (w_fill < AvgWindow) w_fill++;
          if (m_ac > pk_c) pk_c = m_ac;
          if (m_ab > pk_b) pk_b = m_ab;
          sc = '{m_ac, m_ab, m_fc, m_fb, a_ac, a_ab, a_fc, a_fb,
                 w_csum / 64'(w_fill), w_bsum / 64'(w_fill), pk_c, pk_b, viol};
          for (int i = 0; i < ScalarWords; i++) push_word(i, sc[i], 1'b0);
          for (int i = 0; i < HistBuckets; i++) begin
            push_word(ScalarWords + 2 * i, h_calls[i], 1'b0);
            push_word(ScalarWords + 2 * i + 1, h_bytes[i], i == HistBuckets - 1);
          end
        end
      end
    endcase
  endtask

  // Receiver with random stalls; checks every transfer in order.
  always @(posedge clk) begin
    report_word_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected word idx=%0d value=%h", $time, out_tdata[5:0],
                 out_tdata[69:6]);
        errors++;
      end else begin
        exp_w = report_q.pop_front();
        if (out_tdata[5:0] !== exp_w.idx || out_tdata[69:6] !== exp_w.value ||
            out_tlast !== exp_w.last || out_tdata[71:70] !== 2'b00) begin
          $display("%0t: mismatch expected idx=%0d value=%h last=%b actual idx=%0d value=%h last=%b",
                   $time, exp_w.idx, exp_w.value, exp_w.last, out_tdata[5:0],
                   out_tdata[69:6], out_tlast);
          errors++;
        end
      end
    end
  end

  // After every transfer the receiver draws a random wait before it takes the next word.
  int stall_left = 0;
  always @(posedge clk) begin
    int stall_w;
    if (!out_tready) begin
      if (stall_left > 0) stall_left <= stall_left - 1;
      else out_tready <= 1'b1;
    end else if (out_tvalid) begin
      stall_w = $urandom_range(7);
      if (stall_w > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_w - 1;
      end
    end
  end

  bit no_gaps = 1'b0;

  task automatic send_event(event_t e);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser <= e.kind;
    in_tdata <= {5'b00000, e.rec, e.disallow, e.main_thr, e.size};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_event(e);
  endtask

  task automatic release_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    release_input();
    while (report_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_hist_enable(logic v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hist_on = v;
  endtask

  function automatic event_t mk(kind_t k, logic [31:0] sz, logic m, logic d, logic r);
    event_t e;
    e.kind = k; e.size = sz; e.main_thr = m; e.disallow = d; e.rec = r;
    return e;
  endfunction

  function automatic event_t rand_event();
    event_t e;
    int sel;
    sel = $urandom_range(99);
    e.kind = sel < 55 ? KIND_ALLOC : sel < 88 ? KIND_FREE : sel < 93 ? KIND_BEGIN : KIND_END;
    case ($urandom_range(3))
      0: e.size = $urandom();
      1: e.size = 32'd1 << $urandom_range(31);
      default: e.size = $urandom_range(600);
    endcase
    e.main_thr = $urandom_range(1);
    e.disallow = $urandom_range(1);
    e.rec = $urandom_range(5) != 0;
    return e;
  endfunction

  // Directed events; the first report after reset with empty state reads all zero.
  event_t directed [$];
  initial begin
    directed = '{
      mk(KIND_END, 32'd0, 1'b0, 1'b0, 1'b1),
      mk(KIND_END, 32'd0, 1'b0, 1'b0, 1'b0),
      mk(KIND_ALLOC, 32'd0, 1'b1, 1'b0, 1'b0),
      mk(KIND_ALLOC, 32'd16, 1'b1, 1'b1, 1'b0),
      mk(KIND_ALLOC, 32'd17, 1'b0, 1'b1, 1'b1),
      mk(KIND_ALLOC, 32'd32, 1'b1, 1'b0, 1'b0),
      mk(KIND_ALLOC, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0),
      mk(KIND_ALLOC, 32'd262144, 1'b0, 1'b0, 1'b0),
      mk(KIND_ALLOC, 32'd262145, 1'b1, 1'b1, 1'b0),
      mk(KIND_FREE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1),
      mk(KIND_FREE, 32'd5, 1'b0, 1'b0, 1'b0),
      mk(KIND_END, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1),
      mk(KIND_ALLOC, 32'd100, 1'b1, 1'b0, 1'b0),
      mk(KIND_END, 32'd0, 1'b0, 1'b0, 1'b1),
      mk(KIND_BEGIN, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1),
      mk(KIND_END, 32'd0, 1'b0, 1'b0, 1'b1)
    };
  end

  initial begin
    event_t e;
    int n;
    hist_on = 1'b0;
    clear_frame();
    for (int i = 0; i < AvgWindow; i++) begin
      w_calls[i] = '0;
      w_bytes[i] = '0;
    end
    w_pos = 0; w_fill = 0; w_csum = '0; w_bsum = '0; pk_c = '0; pk_b = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first report with nothing counted is all zeros.
    send_event(directed[0]);
    for (int i = 0; i < WordCount; i++) begin
      if (report_q[i].value !== 64'd0 || report_q[i].idx !== 6'(i)) begin
        $display("%0t: mismatch expected idx=%0d value=0 actual idx=%0d value=%h",
                 $time, i, report_q[i].idx, report_q[i].value);
        errors++;
      end
    end
    drain();
    write_hist_enable(1'b1);
    for (int i = 1; i < directed.size(); i++) send_event(directed[i]);
    drain();

    n = 0;
    for (int phase = 0; phase < 4; phase++) begin
      write_hist_enable(phase[0]);
      no_gaps = (phase == 2);
      for (int i = 0; i < 60; i++) begin
        e = rand_event();
        send_event(e);
        n++;
        // Hold off until all report words are out.
        if (phase == 3 && i == 30) drain();
      end
      drain();
    end
    // Push the window past its full length with a long run of recorded frame ends.
    write_hist_enable(1'b1);
    for (int i = 0; i < 125; i++) begin
      if (i % 3 == 0) send_event(mk(KIND_ALLOC, $urandom_range(4000), 1'b1, 1'b0, 1'b0));
      send_event(mk(KIND_END, 32'd0, 1'b0, 1'b0, 1'b1));
    end
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
